// ----- sv/kfrc_pkg.sv -----
// kfrc_pkg: types, codes and helpers for the KCS frame receive checker.
// No dependencies; the top, kfrc_cfg and kfrc_core import it.
`timescale 1ns / 1ps

package kfrc_pkg;

  localparam int HEADER_BYTES = 3;

  localparam logic [7:0] CODE_WRITE_START = 8'h61;
  localparam logic [7:0] CODE_WRITE_END   = 8'h62;

  localparam logic [7:0] NETFN_RST     = 8'hB0;
  localparam logic [7:0] BODY_CODE_RST = 8'h01;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_NETFN     = 1'b0;
  localparam logic REG_BODY_CODE = 1'b1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic [2:0] FS_OK       = 3'd0;
  localparam logic [2:0] FS_PROTOCOL = 3'd1;
  localparam logic [2:0] FS_NETFN    = 3'd2;
  localparam logic [2:0] FS_BODY     = 3'd3;
  localparam logic [2:0] FS_LENGTH   = 3'd4;
  localparam logic [2:0] FS_PEC      = 3'd5;
  localparam logic [2:0] FS_OVERFLOW = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_PEC  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] netfn;
    logic [7:0] body_code;
  } cfg_t;

  typedef struct packed {
    logic       publish_state;
    logic [1:0] state_code;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [2:0] frame_status;
    logic [8:0] payload_length;
  } result_t;

  // SMBus PEC, CRC-8 poly 0x07, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/kfrc_if.sv -----
// kfrc_if: valid/ready channel interfaces for host writes and check results.
// No dependencies.
`timescale 1ns / 1ps

interface kfrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] host_byte;
  logic       is_command;

  modport source(output valid, output host_byte, output is_command, input ready);
  modport sink(input valid, input host_byte, input is_command, output ready);
endinterface

interface kfrc_out_if;
  logic       valid;
  logic       ready;
  logic       publish_state;
  logic [1:0] state_code;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic [2:0] frame_status;
  logic [8:0] payload_length;

  modport source(output valid, output publish_state, output state_code,
                 output payload_valid, output payload_byte, output frame_done,
                 output frame_status, output payload_length, input ready);
  modport sink(input valid, input publish_state, input state_code,
               input payload_valid, input payload_byte, input frame_done,
               input frame_status, input payload_length, output ready);
endinterface

// ----- sv/kcs_frame_receive_check_top.sv -----
// kcs_frame_receive_check_top: KCS write-transfer receiver with header and PEC check.
// Stages: input register, one-step checker, result register; a stall on out_ch holds them.
// Throughput: one host write per cycle while out_ch is not stalled.
// Reset: synchronous rst_n clears frame state to idle and config to 0xB0 / 0x01.
// Depends on kfrc_pkg, kfrc_if, kfrc_cfg, kfrc_core.
`timescale 1ns / 1ps

module kcs_frame_receive_check_top
  import kfrc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kfrc_in_if.sink               in_ch,
  kfrc_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_cmd_r;
  logic       out_v_r;
  result_t    out_res_r;
  result_t    res;
  cfg_t       cfg;
  logic       advance;
  logic       step;

  assign advance     = !out_v_r || out_ch.ready;
  assign step        = advance && in_v_r;
  assign in_ch.ready = !in_v_r || advance;

  kfrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  kfrc_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .host_byte  (in_byte_r),
    .is_command (in_cmd_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.host_byte;
      in_cmd_r  <= in_ch.is_command;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.publish_state  = out_res_r.publish_state;
  assign out_ch.state_code     = out_res_r.state_code;
  assign out_ch.payload_valid  = out_res_r.payload_valid;
  assign out_ch.payload_byte   = out_res_r.payload_byte;
  assign out_ch.frame_done     = out_res_r.frame_done;
  assign out_ch.frame_status   = out_res_r.frame_status;
  assign out_ch.payload_length = out_res_r.payload_length;

endmodule

// ----- sv/kfrc_cfg.sv -----
// kfrc_cfg: APB-style register block holding the expected header bytes.
// Depends on kfrc_pkg.
`timescale 1ns / 1ps

module kfrc_cfg
  import kfrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [7:0] netfn_r;
  logic [7:0] body_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      netfn_r <= NETFN_RST;
      body_r  <= BODY_CODE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NETFN:     netfn_r <= pwdata[7:0];
        REG_BODY_CODE: body_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NETFN:     prdata = {24'd0, netfn_r};
      REG_BODY_CODE: prdata = {24'd0, body_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.netfn     = netfn_r;
  assign cfg.body_code = body_r;

endmodule

// ----- sv/kfrc_core.sv -----
// kfrc_core: frame state, header capture, running PEC and final verdict.
// One host write per step; depends on kfrc_pkg.
`timescale 1ns / 1ps

module kfrc_core
  import kfrc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] host_byte,
  input  logic       is_command,
  input  cfg_t       cfg,
  output result_t    res
);

  localparam int CW = $clog2(HEADER_BYTES + MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] HDR_CNT = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] DC_MAX  = CW'(HEADER_BYTES + MAX_PAYLOAD);

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] dc_r, dc_nxt;
  logic [7:0]    hn_r, hn_nxt;
  logic [7:0]    hb_r, hb_nxt;
  logic [7:0]    hl_r, hl_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic          ovf_r, ovf_nxt;

  logic          short_hdr;
  logic [8:0]    plen_cur;
  logic [7:0]    hn_chk;
  logic [7:0]    hb_chk;

  assign short_hdr = dc_r < HDR_CNT;
  assign plen_cur  = short_hdr ? 9'd0 : 9'(dc_r - HDR_CNT);
  assign hn_chk    = (short_hdr && dc_r == '0) ? host_byte : hn_r;
  assign hb_chk    = (short_hdr && dc_r == CW'(1)) ? host_byte : hb_r;

  always_comb begin
    phase_nxt = phase_r;
    dc_nxt    = dc_r;
    hn_nxt    = hn_r;
    hb_nxt    = hb_r;
    hl_nxt    = hl_r;
    crc_nxt   = crc_r;
    ovf_nxt   = ovf_r;
    res       = '0;
    case (phase_r)
      PH_DATA: begin
        res.publish_state = 1'b1;
        res.state_code    = ST_WRITE;
        if (is_command) begin
          if (host_byte == CODE_WRITE_END) begin
            phase_nxt = PH_PEC;
          end else begin
            res.frame_done     = 1'b1;
            res.frame_status   = FS_PROTOCOL;
            res.payload_length = plen_cur;
            phase_nxt          = PH_IDLE;
          end
        end else if (short_hdr) begin
          if (dc_r == '0) begin
            hn_nxt = host_byte;
          end else if (dc_r == CW'(1)) begin
            hb_nxt = host_byte;
          end else begin
            hl_nxt = host_byte;
          end
          dc_nxt = dc_r + CW'(1);
        end else if (dc_r < DC_MAX) begin
          dc_nxt            = dc_r + CW'(1);
          crc_nxt           = crc8_byte(crc_r, host_byte);
          res.payload_valid = 1'b1;
          res.payload_byte  = host_byte;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      PH_PEC: begin
        res.frame_done = 1'b1;
        phase_nxt      = PH_IDLE;
        if (is_command) begin
          res.frame_status   = FS_PROTOCOL;
          res.payload_length = plen_cur;
        end else begin
          res.publish_state  = 1'b1;
          res.state_code     = ST_READ;
          res.payload_length = plen_cur;
          if (short_hdr) begin
            hn_nxt = hn_chk;
            hb_nxt = hb_chk;
            if (dc_r == CW'(2)) begin
              hl_nxt = host_byte;
            end
            dc_nxt = dc_r + CW'(1);
          end
          if (hn_chk != cfg.netfn) begin
            res.frame_status = FS_NETFN;
          end else if (hb_chk != cfg.body_code) begin
            res.frame_status = FS_BODY;
          end else if (short_hdr) begin
            res.frame_status = FS_LENGTH;
          end else if (ovf_r) begin
            res.frame_status = FS_OVERFLOW;
          end else if ({1'b0, hl_r} != plen_cur) begin
            res.frame_status = FS_LENGTH;
          end else if (crc_r != host_byte) begin
            res.frame_status = FS_PEC;
          end else begin
            res.frame_status = FS_OK;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (!is_command) begin
          res.frame_done   = 1'b1;
          res.frame_status = FS_PROTOCOL;
        end else begin
          res.publish_state = 1'b1;
          res.state_code    = ST_WRITE;
          if (host_byte == CODE_WRITE_START) begin
            dc_nxt    = '0;
            hn_nxt    = '0;
            hb_nxt    = '0;
            hl_nxt    = '0;
            crc_nxt   = '0;
            ovf_nxt   = 1'b0;
            phase_nxt = PH_DATA;
          end else begin
            res.frame_done   = 1'b1;
            res.frame_status = FS_PROTOCOL;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dc_r    <= '0;
      hn_r    <= '0;
      hb_r    <= '0;
      hl_r    <= '0;
      crc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      hn_r    <= hn_nxt;
      hb_r    <= hb_nxt;
      hl_r    <= hl_nxt;
      crc_r   <= crc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTH
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r != PH_DATA && phase_nxt == PH_DATA |=> dc_r == '0 && !ovf_r)
    else $error("frame state not cleared on write start");
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> dc_r == DC_MAX)
    else $error("overflow flagged before payload limit");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r <= DC_MAX)
    else $error("data count past limit");
  a_payload_in_write: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.payload_valid |-> res.publish_state && res.state_code == ST_WRITE
      && !res.frame_done)
    else $error("payload byte outside write state");
`endif

endmodule
